[design/kerp_pkg.sv]
// Shared types and constants for the key-exchange reply parser.
// Used by kerp_parse, kerp_fifo and key_exchange_reply_parser_core; no dependencies.
package kerp_pkg;

  localparam int MAX_STRING_BYTES_DEF = 32;
  localparam int MAX_KEYS_DEF         = 32;

  localparam logic [31:0] CTOR_ID     = 32'h0516_2463;
  localparam logic [31:0] VECTOR_ID   = 32'h1cb5_c415;
  localparam logic [7:0]  SHORT_LEN_MAX = 8'd253;
  localparam logic [7:0]  LONG_LEN_MARK = 8'd254;

  localparam int IDX_W      = 6;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CTOR,
    PH_NONCE,
    PH_SNONCE,
    PH_LEN0,
    PH_LENX,
    PH_STR,
    PH_PAD,
    PH_VECID,
    PH_COUNT,
    PH_KEYS
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONCE  = 3'd0,
    KIND_SNONCE = 3'd1,
    KIND_STRB   = 3'd2,
    KIND_KEY    = 3'd3,
    KIND_ACCEPT = 3'd4,
    KIND_ERROR  = 3'd5
  } item_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_CTOR  = 3'd1,
    ERR_LEN   = 3'd2,
    ERR_VEC   = 3'd3,
    ERR_KEYS  = 3'd4,
    ERR_TRUNC = 3'd5
  } err_code_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       first_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    item_kind_t       item_kind;
    logic [IDX_W-1:0] item_index;
    logic [63:0]      item_value;
    logic             run_last;
  } out_item_t;

  // Up to two result items produced by one byte.
  typedef struct packed {
    logic [1:0] num;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

endpackage

[design/kerp_parse.sv]
// Byte-serial parse state machine: consumes one byte per step, emits up to two items.
// Depends on kerp_pkg.
module kerp_parse #(
  parameter int MAX_STRING_BYTES = kerp_pkg::MAX_STRING_BYTES_DEF,
  parameter int MAX_KEYS         = kerp_pkg::MAX_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  kerp_pkg::in_item_t in_item,
  output kerp_pkg::push_t   push
);
  import kerp_pkg::*;

  localparam int SLEN_W = $clog2(MAX_STRING_BYTES + 1);
  localparam int KCNT_W = $clog2(MAX_KEYS + 1);
  localparam int CNT_W  = (SLEN_W > 5) ? SLEN_W : 5;

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [63:0]         word_r, word_nxt;
  logic [SLEN_W-1:0]   slen_r, slen_nxt;
  logic [KCNT_W-1:0]   ktot_r, ktot_nxt;
  logic [KCNT_W-1:0]   knum_r, knum_nxt;
  logic [1:0]          pad_r, pad_nxt;

  // state after a possible restart
  phase_t              ph;
  logic [CNT_W-1:0]    cnt;
  logic [63:0]         word;
  logic [SLEN_W-1:0]   slen;
  logic [KCNT_W-1:0]   ktot;
  logic [KCNT_W-1:0]   knum;
  logic [1:0]          pad;

  logic [63:0]         g_word;
  logic [CNT_W-1:0]    g_cnt;
  logic [KCNT_W-1:0]   knum_inc;
  logic                active;
  logic                accept;
  err_code_t           err;
  logic                dat_v;
  out_item_t           dat;
  out_item_t           fin;
  logic                fin_v;
  logic                do_len;
  logic                long_form;
  logic [23:0]         len_val;

  always_comb begin
    ph   = phase_r;
    cnt  = cnt_r;
    word = word_r;
    slen = slen_r;
    ktot = ktot_r;
    knum = knum_r;
    pad  = pad_r;
    if (in_item.first_byte) begin
      ph   = PH_CTOR;
      cnt  = '0;
      word = '0;
      slen = '0;
      ktot = '0;
      knum = '0;
      pad  = '0;
    end

    g_word   = word | ({56'd0, in_item.msg_byte} << {cnt[2:0], 3'b000});
    g_cnt    = cnt + 1'b1;
    knum_inc = knum + 1'b1;

    phase_nxt = ph;
    cnt_nxt   = cnt;
    word_nxt  = word;
    slen_nxt  = slen;
    ktot_nxt  = ktot;
    knum_nxt  = knum;
    pad_nxt   = pad;

    active    = 1'b1;
    accept    = 1'b0;
    err       = ERR_NONE;
    dat_v     = 1'b0;
    dat       = '0;
    do_len    = 1'b0;
    long_form = 1'b0;
    len_val   = '0;

    unique case (ph)
      PH_IDLE: begin
        active = 1'b0;
      end
      PH_CTOR, PH_VECID: begin
        cnt_nxt  = g_cnt;
        word_nxt = g_word;
        if (g_cnt == CNT_W'(4)) begin
          if (ph == PH_CTOR) begin
            if (g_word[31:0] != CTOR_ID) err = ERR_CTOR;
            else phase_nxt = PH_NONCE;
          end else begin
            if (g_word[31:0] != VECTOR_ID) err = ERR_VEC;
            else phase_nxt = PH_COUNT;
          end
          cnt_nxt  = '0;
          word_nxt = '0;
        end
      end
      PH_NONCE, PH_SNONCE: begin
        cnt_nxt  = g_cnt;
        word_nxt = g_word;
        if (g_cnt[2:0] == 3'd0) begin
          dat_v           = 1'b1;
          dat.item_kind   = (ph == PH_NONCE) ? KIND_NONCE : KIND_SNONCE;
          dat.item_index  = IDX_W'(g_cnt[4:3] - 2'd1);
          dat.item_value  = g_word;
          word_nxt        = '0;
          if (g_cnt == CNT_W'(16)) begin
            phase_nxt = (ph == PH_NONCE) ? PH_SNONCE : PH_LEN0;
            cnt_nxt   = '0;
          end
        end
      end
      PH_LEN0: begin
        if (in_item.msg_byte <= SHORT_LEN_MAX) begin
          do_len  = 1'b1;
          len_val = {16'd0, in_item.msg_byte};
        end else if (in_item.msg_byte == LONG_LEN_MARK) begin
          phase_nxt = PH_LENX;
          cnt_nxt   = '0;
          word_nxt  = '0;
        end else begin
          err = ERR_LEN;
        end
      end
      PH_LENX: begin
        cnt_nxt  = g_cnt;
        word_nxt = g_word;
        if (g_cnt == CNT_W'(3)) begin
          do_len    = 1'b1;
          long_form = 1'b1;
          len_val   = g_word[23:0];
        end
      end
      PH_STR: begin
        dat_v          = 1'b1;
        dat.item_kind  = KIND_STRB;
        dat.item_index = IDX_W'(cnt);
        dat.item_value = {56'd0, in_item.msg_byte};
        cnt_nxt        = g_cnt;
        if (g_cnt >= CNT_W'(slen)) begin
          phase_nxt = (pad != 2'd0) ? PH_PAD : PH_VECID;
          cnt_nxt   = '0;
          word_nxt  = '0;
        end
      end
      PH_PAD: begin
        pad_nxt = pad - 2'd1;
        if (pad_nxt == 2'd0) begin
          phase_nxt = PH_VECID;
          cnt_nxt   = '0;
          word_nxt  = '0;
        end
      end
      PH_COUNT: begin
        cnt_nxt  = g_cnt;
        word_nxt = g_word;
        if (g_cnt == CNT_W'(4)) begin
          if (g_word[31:0] > 32'(MAX_KEYS)) begin
            err = ERR_KEYS;
          end else begin
            ktot_nxt = KCNT_W'(g_word[31:0]);
            knum_nxt = '0;
            if (g_word[31:0] == 32'd0) begin
              accept = 1'b1;
            end else begin
              phase_nxt = PH_KEYS;
              cnt_nxt   = '0;
              word_nxt  = '0;
            end
          end
        end
      end
      PH_KEYS: begin
        cnt_nxt  = g_cnt;
        word_nxt = g_word;
        if (g_cnt == CNT_W'(8)) begin
          dat_v          = 1'b1;
          dat.item_kind  = KIND_KEY;
          dat.item_index = IDX_W'(knum);
          dat.item_value = g_word;
          knum_nxt       = knum_inc;
          cnt_nxt        = '0;
          word_nxt       = '0;
          if (knum_inc >= ktot) accept = 1'b1;
        end
      end
      default: begin
        active    = 1'b0;
        phase_nxt = PH_IDLE;
      end
    endcase

    // string length, short or long form
    if (do_len) begin
      if (len_val > 24'(MAX_STRING_BYTES)) begin
        err = ERR_LEN;
      end else begin
        slen_nxt = SLEN_W'(len_val);
        pad_nxt  = long_form ? (2'd0 - len_val[1:0]) : ~len_val[1:0];
        cnt_nxt  = '0;
        word_nxt = '0;
        if (len_val != 24'd0) phase_nxt = PH_STR;
        else phase_nxt = (pad_nxt != 2'd0) ? PH_PAD : PH_VECID;
      end
    end

    fin_v          = 1'b0;
    fin            = '0;
    fin.item_kind  = KIND_ERROR;
    fin.run_last   = 1'b1;
    if (active) begin
      if (err != ERR_NONE) begin
        fin_v          = 1'b1;
        fin.item_value = 64'(err);
        phase_nxt      = PH_IDLE;
      end else if (accept) begin
        fin_v          = 1'b1;
        fin.item_kind  = KIND_ACCEPT;
        fin.item_index = IDX_W'(ktot_nxt);
        fin.item_value = 64'(slen_nxt);
        phase_nxt      = PH_IDLE;
      end else if (in_item.final_byte) begin
        fin_v          = 1'b1;
        fin.item_value = 64'(ERR_TRUNC);
        phase_nxt      = PH_IDLE;
      end
    end

    push = '0;
    if (step) begin
      if (dat_v) begin
        push.item0 = dat;
        push.item1 = fin;
        push.num   = fin_v ? 2'd2 : 2'd1;
      end else if (fin_v) begin
        push.item0 = fin;
        push.num   = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      slen_r  <= '0;
      ktot_r  <= '0;
      knum_r  <= '0;
      pad_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      slen_r  <= slen_nxt;
      ktot_r  <= ktot_nxt;
      knum_r  <= knum_nxt;
      pad_r   <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) word_r <= word_nxt;
  end

  // an ending item is always the last one pushed for its byte
  a_last_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.num == 2'd2 |-> push.item1.run_last && !push.item0.run_last)
    else $error("ending item not last");

  // after an ending item the parser waits for the next first byte
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd0) && ((push.num == 2'd2) ? push.item1.run_last : push.item0.run_last)
    |=> phase_r == PH_IDLE)
    else $error("parser not idle after ending item");

  // without a restart, a waiting parser produces nothing
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) && !in_item.first_byte |-> push.num == 2'd0)
    else $error("items produced while waiting");

endmodule

[design/kerp_fifo.sv]
// Four-entry result queue taking up to two items per cycle, one out per cycle.
// Depends on kerp_pkg.
module kerp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  kerp_pkg::push_t     push,
  input  logic                pop,
  output logic                room,
  output logic                out_valid,
  output kerp_pkg::out_item_t out_item
);
  import kerp_pkg::*;

  out_item_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_r, wr_nxt;
  logic [FIFO_AW-1:0]   rd_r, rd_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic [FIFO_AW-1:0]   wr_p1;

  assign wr_p1     = wr_r + 1'b1;
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_r];
  // room for two regardless of this cycle's pop
  assign room      = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));

  always_comb begin
    wr_nxt    = wr_r + FIFO_AW'(push.num);
    rd_nxt    = rd_r + FIFO_AW'(pop);
    count_nxt = count_r + FIFO_CW'(push.num) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) mem_r[wr_r] <= push.item0;
    if (push.num == 2'd2) mem_r[wr_p1] <= push.item1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.num != 2'd0 |-> (count_r + FIFO_CW'(push.num) - FIFO_CW'(pop))
                         <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

endmodule

[design/key_exchange_reply_parser_core.sv]
// Top level of the key-exchange reply parser: input register, parse logic, result queue.
// Depends on kerp_pkg, kerp_parse and kerp_fifo.
//
//  port group | dir | payload              | handshake
//  -----------+-----+----------------------+------------------------------
//  in_*       | in  | in_item_t  (10 bits) | in_valid / in_stall (to us)
//  out_*      | out | out_item_t (74 bits) | out_valid / out_stall (from sink)
//
// One byte per clock sustained while the queue has room. A request is held in the
// input register and parsed there in a single pass; its items are written to the queue.
// A byte may make two items (data item plus end item); the four-entry queue
// absorbs the extra item, and in_stall rises only while fewer than two slots are free.
// Synchronous active-low reset puts the parser in the waiting phase and empties the queue.
// out_stall only holds the queue; bytes keep flowing until fewer than two slots are free.
module key_exchange_reply_parser_core #(
  parameter int MAX_STRING_BYTES = kerp_pkg::MAX_STRING_BYTES_DEF,
  parameter int MAX_KEYS         = kerp_pkg::MAX_KEYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kerp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kerp_pkg::out_item_t out_data
);
  import kerp_pkg::*;

  in_item_t in_r;
  logic     in_vld_r, in_vld_nxt;
  logic     room;
  logic     step;
  logic     load;
  logic     pop;
  push_t    push;

  // parse the held byte when the queue can take its worst case of two items
  assign step     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign load     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (load) in_vld_nxt = 1'b1;
    else if (step) in_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) in_r <= in_data;
  end

  kerp_parse #(
    .MAX_STRING_BYTES (MAX_STRING_BYTES),
    .MAX_KEYS         (MAX_KEYS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_item (in_r),
    .push    (push)
  );

  kerp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .room      (room),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

  // a held byte that was not parsed is still held next cycle
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !step |=> in_vld_r && $stable(in_r))
    else $error("held request lost");

  // the queue only ever receives items from a parsed byte
  a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
    push.num != 2'd0 |-> step)
    else $error("items pushed without a parsed byte");

endmodule
